// ----- design/line_edit_buffer_assert.svh -----
// ----------------------------------------------------------------------------
// Line edit buffer assertion macros
// Shared property forms for the checker of the line edit buffer. They expect
// clk and arst_n to be visible where they are used.
// ----------------------------------------------------------------------------
`ifndef LINE_EDIT_BUFFER_ASSERT_SVH
`define LINE_EDIT_BUFFER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define LEB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LEB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/leb_pkg.sv -----
// ----------------------------------------------------------------------------
// Line edit buffer package
// Widths, character codes, result action codes and the command type that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package leb_pkg;

	localparam int MAX_LINE = 64;
	localparam int ADDR_W   = $clog2(MAX_LINE);
	localparam int CNT_W    = $clog2(MAX_LINE + 1);

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	localparam logic [2:0] ACT_ECHO    = 3'd0;
	localparam logic [2:0] ACT_ERASE   = 3'd1;
	localparam logic [2:0] ACT_BELL    = 3'd2;
	localparam logic [2:0] ACT_REFRESH = 3'd3;
	localparam logic [2:0] ACT_BYTE    = 3'd4;
	localparam logic [2:0] ACT_EMPTY   = 3'd5;

	localparam logic [1:0] CFG_ERASE  = 2'd0;
	localparam logic [1:0] CFG_KILL   = 2'd1;
	localparam logic [1:0] CFG_WERASE = 2'd2;
	localparam logic [1:0] CFG_LIMIT  = 2'd3;

	typedef enum logic [2:0] {
		OP_ERASE   = 3'd0,
		OP_KILL    = 3'd1,
		OP_WERASE  = 3'd2,
		OP_REFRESH = 3'd3,
		OP_EOL     = 3'd4,
		OP_PRINT   = 3'd5,
		OP_BELL    = 3'd6
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] key;
	} cmd_t;

endpackage

// ----- design/leb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module leb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/leb_front.sv -----
// ----------------------------------------------------------------------------
// Line edit buffer front end
// Accepts typed bytes, classifies them against the control characters and
// holds the resulting command in one register stage.
// ----------------------------------------------------------------------------
module leb_front import leb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       key_valid,
	output logic       key_ready,
	input  logic [7:0] key_byte,
	input  logic [7:0] erase_char,
	input  logic [7:0] kill_char,
	input  logic [7:0] word_erase_char,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	logic vld_s1;
	cmd_t cmd_s1;
	op_t  op;

	always_comb begin
		if (key_byte == erase_char) begin
			op = OP_ERASE;
		end else if (key_byte == kill_char) begin
			op = OP_KILL;
		end else if (key_byte == word_erase_char) begin
			op = OP_WERASE;
		end else if (key_byte == CH_FF) begin
			op = OP_REFRESH;
		end else if (key_byte inside {CH_LF, CH_CR}) begin
			op = OP_EOL;
		end else if (key_byte inside {[CH_SP:CH_TILDE]}) begin
			op = OP_PRINT;
		end else begin
			op = OP_BELL;
		end
	end

	assign key_ready = !vld_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (key_valid && key_ready) begin
			vld_s1 <= 1'b1;
		end else if (cmd_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (key_valid && key_ready) begin
			cmd_s1.op  <= op;
			cmd_s1.key <= key_byte;
		end
	end

	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

endmodule

// ----- design/leb_queue.sv -----
// ----------------------------------------------------------------------------
// Line edit buffer command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module leb_queue import leb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_pop,
	output cmd_t out_cmd
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign out_cmd   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

// ----- design/leb_back.sv -----
// ----------------------------------------------------------------------------
// Line edit buffer back end
// Owns the line store and the character count, carries out the commands and
// drives the result register. Word erase and line emission walk the store.
// ----------------------------------------------------------------------------
module leb_back import leb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	input  logic [CNT_W-1:0] line_limit,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [2:0]       action,
	output logic [7:0]       out_byte,
	output logic [CNT_W-1:0] erase_count,
	output logic             last
);

	typedef enum logic [3:0] {
		BK_IDLE  = 4'b0001,
		BK_WCHK  = 4'b0010,
		BK_WDONE = 4'b0100,
		BK_EMIT  = 4'b1000
	} bk_state_t;

	bk_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] n_q, n_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] len_q, len_d;
	logic             phase_q, phase_d;

	logic             res_valid_q;
	logic [2:0]       action_q;
	logic [7:0]       byte_q;
	logic [CNT_W-1:0] ecnt_q;
	logic             last_q;

	logic             load;
	logic [2:0]       ld_act;
	logic [7:0]       ld_byte;
	logic [CNT_W-1:0] ld_cnt;
	logic             ld_last;

	logic              we;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;

	logic [CNT_W-1:0] lim;
	logic [CNT_W-1:0] emit_len;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] cnt_m2;
	logic [CNT_W-1:0] idx_p1;
	logic             out_free;
	logic             blank;

	assign lim      = (line_limit > CNT_W'(MAX_LINE)) ? CNT_W'(MAX_LINE) : line_limit;
	assign emit_len = (cnt_q < lim) ? cnt_q : lim;
	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign cnt_m2   = cnt_q - CNT_W'(2);
	assign idx_p1   = idx_q + CNT_W'(1);
	assign out_free = !res_valid_q || res_ready;
	assign blank    = (rdata == CH_SP) || (rdata == CH_TAB);

	leb_ram #(
		.WIDTH (8),
		.DEPTH (MAX_LINE)
	) u_line_store (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (cmd.key),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		n_d     = n_q;
		idx_d   = idx_q;
		len_d   = len_q;
		phase_d = phase_q;
		cmd_pop = 1'b0;
		we      = 1'b0;
		raddr   = cnt_m1[ADDR_W-1:0];
		load    = 1'b0;
		ld_act  = ACT_BELL;
		ld_byte = 8'd0;
		ld_cnt  = '0;
		ld_last = 1'b1;
		case (state_q)
			BK_IDLE: begin
				if (cmd.op == OP_EOL) begin
					raddr = '0;
				end
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_ERASE: begin
							load = 1'b1;
							if (cnt_q != '0) begin
								cnt_d  = cnt_m1;
								ld_act = ACT_ERASE;
								ld_cnt = CNT_W'(1);
							end
						end
						OP_KILL: begin
							if (cnt_q != '0) begin
								load   = 1'b1;
								ld_act = ACT_ERASE;
								ld_cnt = cnt_q;
								cnt_d  = '0;
							end
						end
						OP_WERASE: begin
							if (cnt_q != '0) begin
								n_d     = '0;
								phase_d = 1'b1;
								state_d = BK_WCHK;
							end
						end
						OP_REFRESH: begin
							load   = 1'b1;
							ld_act = ACT_REFRESH;
						end
						OP_EOL: begin
							cnt_d = '0;
							if (emit_len == '0) begin
								load   = 1'b1;
								ld_act = ACT_EMPTY;
							end else begin
								len_d   = emit_len;
								idx_d   = '0;
								state_d = BK_EMIT;
							end
						end
						OP_PRINT: begin
							load = 1'b1;
							if (cnt_q < lim) begin
								we      = 1'b1;
								cnt_d   = cnt_q + CNT_W'(1);
								ld_act  = ACT_ECHO;
								ld_byte = cmd.key;
							end
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			BK_WCHK: begin
				raddr = cnt_m2[ADDR_W-1:0];
				if (phase_q && !blank || phase_q || !blank) begin
					cnt_d   = cnt_m1;
					n_d     = n_q + CNT_W'(1);
					phase_d = phase_q && blank;
					if (cnt_m1 == '0) begin
						state_d = BK_WDONE;
					end
				end else begin
					state_d = BK_WDONE;
				end
			end
			BK_WDONE: begin
				if (out_free) begin
					state_d = BK_IDLE;
					if (n_q != '0) begin
						load   = 1'b1;
						ld_act = ACT_ERASE;
						ld_cnt = n_q;
					end
				end
			end
			BK_EMIT: begin
				raddr = out_free ? idx_p1[ADDR_W-1:0] : idx_q[ADDR_W-1:0];
				if (out_free) begin
					load    = 1'b1;
					ld_act  = ACT_BYTE;
					ld_byte = rdata;
					ld_last = (idx_p1 == len_q);
					idx_d   = idx_p1;
					if (idx_p1 == len_q) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		n_q     <= n_d;
		idx_q   <= idx_d;
		len_q   <= len_d;
		phase_q <= phase_d;
		if (load) begin
			action_q <= ld_act;
			byte_q   <= ld_byte;
			ecnt_q   <= ld_cnt;
			last_q   <= ld_last;
		end
	end

	assign res_valid   = res_valid_q;
	assign action      = action_q;
	assign out_byte    = byte_q;
	assign erase_count = ecnt_q;
	assign last        = last_q;

endmodule

// ----- design/line_edit_buffer.sv -----
// ----------------------------------------------------------------------------
// Line edit buffer
// Keeps an editable line of typed bytes and reports the display actions that
// each byte causes, emitting the stored line up to the line limit on LF or CR.
//
// Key bytes enter on the key channel (key_valid, key_ready, key_byte). Each
// key gives zero or more results on the result channel (res_valid, res_ready,
// action, out_byte, erase_count, last); last marks the final result of a key.
// Control characters and the line limit are set through cfg_we, cfg_index and
// cfg_data; the user is to write them only while the block is idle, which the
// block itself does not enforce. A key passes the front end register and the
// command queue to the back end, whose results wait in the result register.
// The back end takes a simple key while idle and the result register is free;
// word erase walks the line store back a character at a time and end of line
// emits the line byte by byte via the single read port, taking no new key.
// Reset empties the line and loads the default control characters; the line
// store itself is not cleared. When the receiver stalls, the result register
// holds and the two-entry command queue keeps taking keys until it fills.
// ----------------------------------------------------------------------------
module line_edit_buffer import leb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             key_valid,
	output logic             key_ready,
	input  logic [7:0]       key_byte,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [2:0]       action,
	output logic [7:0]       out_byte,
	output logic [CNT_W-1:0] erase_count,
	output logic             last
);

	logic [7:0]       erase_q;
	logic [7:0]       kill_q;
	logic [7:0]       werase_q;
	logic [CNT_W-1:0] limit_q;

	logic fr_valid;
	logic fr_ready;
	cmd_t fr_cmd;
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_q  <= 8'd8;
			kill_q   <= 8'd21;
			werase_q <= 8'd23;
			limit_q  <= CNT_W'(MAX_LINE);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ERASE:  erase_q  <= cfg_data;
				CFG_KILL:   kill_q   <= cfg_data;
				CFG_WERASE: werase_q <= cfg_data;
				CFG_LIMIT:  limit_q  <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	leb_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.key_valid       (key_valid),
		.key_ready       (key_ready),
		.key_byte        (key_byte),
		.erase_char      (erase_q),
		.kill_char       (kill_q),
		.word_erase_char (werase_q),
		.cmd_valid       (fr_valid),
		.cmd_ready       (fr_ready),
		.cmd             (fr_cmd)
	);

	leb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_cmd    (fr_cmd),
		.out_valid (q_valid),
		.out_pop   (q_pop),
		.out_cmd   (q_cmd)
	);

	leb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (q_valid),
		.cmd         (q_cmd),
		.cmd_pop     (q_pop),
		.line_limit  (limit_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.action      (action),
		.out_byte    (out_byte),
		.erase_count (erase_count),
		.last        (last)
	);

endmodule

// ----- design/leb_checker.sv -----
// ----------------------------------------------------------------------------
// Line edit buffer checker
// Watches the result channel of the line edit buffer, checks that a stalled
// result holds and checks the payload rules that follow from each action.
// ----------------------------------------------------------------------------
`include "line_edit_buffer_assert.svh"

module leb_checker import leb_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_ready,
	input logic [2:0]       action,
	input logic [7:0]       out_byte,
	input logic [CNT_W-1:0] erase_count,
	input logic             last
);

	`LEB_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(action) && $stable(out_byte) && $stable(erase_count) && $stable(last), "result changed while stalled")

	`LEB_ASSERT_SAME(a_single_last, res_valid && action != ACT_BYTE, last, "single result not marked last")

	`LEB_ASSERT_SAME(a_echo_printable, res_valid && action == ACT_ECHO, out_byte >= CH_SP && out_byte <= CH_TILDE, "echo of a non-printable byte")

	`LEB_ASSERT_SAME(a_erase_count, res_valid, (action == ACT_ERASE) ? (erase_count != '0 && erase_count <= CNT_W'(MAX_LINE)) : (erase_count == '0), "erase count inconsistent with action")

endmodule

bind line_edit_buffer leb_checker u_leb_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line edit buffer testbench
// Drives typed bytes into the line edit buffer and checks every display
// result against a behavioral line editor kept in a scoreboard. A directed
// opening covers the control characters, the byte range edges and the empty
// line cases. Random phases then run under several control character and
// line limit settings, with random stalls on both channels, a long receiver
// hold-off and full-length lines.
// ----------------------------------------------------------------------------

import leb_pkg::*;

typedef struct packed {
	logic [2:0]       act;
	logic [7:0]       ch;
	logic [CNT_W-1:0] cnt;
	logic             fin;
} edit_result_t;

class edit_scoreboard;
	logic [7:0]   line_mem [MAX_LINE];
	int unsigned  fill;
	logic [7:0]   erase_key;
	logic [7:0]   kill_key;
	logic [7:0]   werase_key;
	logic [6:0]   limit_reg;
	edit_result_t pending [$];
	int unsigned  errors;

	function new();
		fill       = 0;
		erase_key  = 8'h08;
		kill_key   = 8'h15;
		werase_key = 8'h17;
		limit_reg  = 7'd64;
		errors     = 0;
	endfunction

	function void report(string msg);
		errors++;
		if (errors <= 50) begin
			$display("%0t mismatch: %s", $realtime, msg);
		end
	endfunction

	function void write_reg(logic [1:0] idx, logic [7:0] val);
		case (idx)
			CFG_ERASE: begin
				erase_key = val;
			end
			CFG_KILL: begin
				kill_key = val;
			end
			CFG_WERASE: begin
				werase_key = val;
			end
			CFG_LIMIT: begin
				limit_reg = val[6:0];
			end
			default: begin
			end
		endcase
	endfunction

	function void push(logic [2:0] act, logic [7:0] ch, int unsigned cnt, logic fin);
		edit_result_t r;
		r.act = act;
		r.ch  = ch;
		r.cnt = CNT_W'(cnt);
		r.fin = fin;
		pending.push_back(r);
	endfunction

	// Applies one typed byte to the line and queues the results it causes.
	function int note_key(logic [7:0] c);
		int unsigned lim;
		int unsigned n;
		lim = (limit_reg > MAX_LINE) ? MAX_LINE : limit_reg;
		if (c == erase_key) begin
			if (fill > 0) begin
				fill--;
				push(ACT_ERASE, 8'h00, 1, 1'b1);
			end else begin
				push(ACT_BELL, 8'h00, 0, 1'b1);
			end
			return 1;
		end
		if (c == kill_key) begin
			if (fill == 0) begin
				return 0;
			end
			push(ACT_ERASE, 8'h00, fill, 1'b1);
			fill = 0;
			return 1;
		end
		if (c == werase_key) begin
			n = 0;
			while (fill > 0 && (line_mem[fill-1] == CH_SP || line_mem[fill-1] == CH_TAB)) begin
				fill--;
				n++;
			end
			while (fill > 0 && !(line_mem[fill-1] == CH_SP || line_mem[fill-1] == CH_TAB)) begin
				fill--;
				n++;
			end
			if (n == 0) begin
				return 0;
			end
			push(ACT_ERASE, 8'h00, n, 1'b1);
			return 1;
		end
		if (c == CH_FF) begin
			push(ACT_REFRESH, 8'h00, 0, 1'b1);
			return 1;
		end
		if (c == CH_LF || c == CH_CR) begin
			n = (fill < lim) ? fill : lim;
			fill = 0;
			if (n == 0) begin
				push(ACT_EMPTY, 8'h00, 0, 1'b1);
				return 1;
			end
			for (int unsigned j = 0; j < n; j++) begin
				push(ACT_BYTE, line_mem[j], 0, j + 1 == n);
			end
			return n;
		end
		if (c < CH_SP || c > CH_TILDE || fill >= lim) begin
			push(ACT_BELL, 8'h00, 0, 1'b1);
			return 1;
		end
		line_mem[fill] = c;
		fill++;
		push(ACT_ECHO, c, 0, 1'b1);
		return 1;
	endfunction

	function void check_result(logic [2:0] act, logic [7:0] ch, logic [CNT_W-1:0] cnt,
			logic fin);
		edit_result_t want;
		if (pending.size() == 0) begin
			report($sformatf("unexpected result: action %0d byte %02h count %0d", act, ch, cnt));
			return;
		end
		want = pending.pop_front();
		if (act !== want.act) begin
			report($sformatf("action %0d, expected %0d", act, want.act));
		end
		if (ch !== want.ch) begin
			report($sformatf("out_byte %02h, expected %02h", ch, want.ch));
		end
		if (cnt !== want.cnt) begin
			report($sformatf("erase_count %0d, expected %0d", cnt, want.cnt));
		end
		if (fin !== want.fin) begin
			report($sformatf("last %0b, expected %0b", fin, want.fin));
		end
	endfunction
endclass

module tb;

	localparam logic [7:0] KEY_BS  = 8'h08;
	localparam logic [7:0] KEY_NAK = 8'h15;
	localparam logic [7:0] KEY_ETB = 8'h17;
	localparam logic [7:0] KEY_DEL = 8'h7F;

	logic             clk;
	logic             arst_n;
	logic             key_valid;
	logic             key_ready;
	logic [7:0]       key_byte;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [7:0]       cfg_data;
	logic             res_valid;
	logic             res_ready;
	logic [2:0]       action;
	logic [7:0]       out_byte;
	logic [CNT_W-1:0] erase_count;
	logic             last;

	edit_scoreboard sb = new();

	int send_idle = 32;
	int recv_idle = 59;
	int stall_seq = 0;
	int answered  = 0;

	line_edit_buffer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (key_valid),
		.key_ready  (key_ready),
		.key_byte   (key_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.action     (action),
		.out_byte   (out_byte),
		.erase_count(erase_count),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb NOT OK");
		$finish;
	end

	// Result side: checks each transfer and keeps the ready pattern, including
	// long hold-offs requested by the stimulus process.
	initial begin
		int stall_seen;
		int stall_left;
		stall_seen = 0;
		stall_left = 0;
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && res_ready) begin
				sb.check_result(action, out_byte, erase_count, last);
			end
			if (stall_seq != stall_seen) begin
				stall_seen = stall_seq;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic send_key(input logic [7:0] b);
		if ($urandom_range(99) < send_idle) begin
			key_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		key_valid <= 1'b1;
		key_byte  <= b;
		do @(posedge clk); while (!key_ready);
		if (sb.note_key(b) > 0) begin
			answered++;
		end
	endtask

	task automatic settle();
		key_valid <= 1'b0;
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic set_regs(input logic [7:0] er, input logic [7:0] kl,
			input logic [7:0] wk, input logic [7:0] lim);
		settle();
		write_reg(CFG_ERASE, er);
		write_reg(CFG_KILL, kl);
		write_reg(CFG_WERASE, wk);
		write_reg(CFG_LIMIT, lim);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 45) begin
			return 8'($urandom_range(8'h21, 8'h7E));
		end else if (r < 57) begin
			return CH_SP;
		end else if (r < 63) begin
			return sb.erase_key;
		end else if (r < 66) begin
			return sb.kill_key;
		end else if (r < 73) begin
			return sb.werase_key;
		end else if (r < 75) begin
			return CH_FF;
		end else if (r < 82) begin
			return ($urandom_range(1) != 0) ? CH_LF : CH_CR;
		end
		return 8'($urandom_range(255));
	endfunction

	task automatic run_random(input int goal);
		int target;
		target = answered + goal;
		while (answered < target) begin
			send_key(pick_key());
		end
	endtask

	task automatic type_text(input int len);
		for (int i = 0; i < len; i++) begin
			send_key(8'($urandom_range(8'h21, 8'h7E)));
		end
	endtask

	initial begin
		logic [7:0] opening [23];
		opening = '{KEY_BS, KEY_NAK, KEY_ETB, CH_FF, CH_LF, CH_SP, CH_TILDE, 8'h61,
			CH_TAB, 8'h1F, KEY_DEL, 8'hFF, 8'h00, 8'h62, CH_SP, CH_SP, KEY_ETB, KEY_BS,
			8'h63, CH_CR, 8'h78, KEY_NAK, CH_LF};
		arst_n    = 1'b0;
		key_valid = 1'b0;
		key_byte  = 8'h00;
		cfg_we    = 1'b0;
		cfg_index = CFG_ERASE;
		cfg_data  = 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) begin
			send_key(opening[i]);
		end
		run_random(10);

		set_regs(KEY_DEL, KEY_NAK, KEY_ETB, 8'd8);
		run_random(10);

		send_idle = 59;
		recv_idle = 32;
		// All three editing characters on one letter: erase takes priority.
		set_regs(8'h61, 8'h61, 8'h61, 8'd64);
		send_key(8'h61);
		send_key(8'h62);
		send_key(8'h62);
		send_key(8'h61);
		run_random(5);
		// Editing characters that shadow refresh, newline and space.
		set_regs(CH_FF, CH_LF, CH_SP, 8'd1);
		send_key(CH_FF);
		send_key(8'h41);
		send_key(8'h42);
		send_key(CH_SP);
		send_key(CH_LF);
		send_key(CH_CR);
		run_random(5);

		set_regs(8'h00, 8'hFF, 8'h80, 8'd0);
		send_key(CH_SP);
		send_key(CH_TILDE);
		send_key(CH_CR);
		run_random(5);

		// Limit written as 127 acts as a full line. The receiver is held off
		// while a full line is typed, so the input side backs up.
		set_regs(KEY_BS, KEY_NAK, KEY_ETB, 8'hFF);
		stall_seq <= stall_seq + 1;
		type_text(66);
		send_key(CH_LF);
		run_random(5);

		send_idle = 0;
		recv_idle = 0;
		// Lowering the limit under a partly typed line.
		set_regs(KEY_BS, KEY_NAK, KEY_ETB, 8'd64);
		type_text(12);
		set_regs(KEY_BS, KEY_NAK, KEY_ETB, 8'd5);
		send_key(8'h7A);
		send_key(KEY_BS);
		send_key(CH_SP);
		send_key(CH_LF);
		type_text(4);
		send_key(CH_SP);
		type_text(3);
		send_key(KEY_ETB);
		send_key(CH_CR);

		set_regs(KEY_BS, KEY_NAK, KEY_ETB, 8'd64);
		type_text(30);
		send_key(CH_CR);
		run_random(10);

		settle();
		repeat (100) @(posedge clk);
		if (sb.pending.size() != 0) begin
			sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));
		end
		if (sb.errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
